[rtl/ajb_pkg.sv]
// ----------------------------------------------------------------------------
// Audio jitter buffer package
// Event codes, receive status codes and clock trim codes shared by the
// jitter buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ajb_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int THR_W    = 5;
  localparam int TRIM_W   = 2;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [THR_W-1:0]           thr_t;
  typedef logic signed [TRIM_W-1:0]   trim_t;

  localparam kind_t KIND_FRAME   = 2'd0;
  localparam kind_t KIND_DONE    = 2'd1;
  localparam kind_t KIND_RESTART = 2'd2;

  localparam status_t RX_OK      = 2'd0;
  localparam status_t RX_ABORTED = 2'd1;

  localparam trim_t TRIM_NONE   = 2'sb00;
  localparam trim_t TRIM_FASTER = 2'sb01;
  localparam trim_t TRIM_SLOWER = 2'sb11;

  localparam thr_t THR_RESET = 5'd8;

endpackage

`default_nettype wire

[rtl/audio_jitter_buffer_ring_top.sv]
// ----------------------------------------------------------------------------
// Audio jitter buffer ring
// Ring of frame slots between a packet receiver and a DAC, with playback
// control and clock trim tracking of the fill level.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is an event: a received frame, a DAC playback done, or a
// stream restart. Every accepted item gives exactly one result item that
// reports any slot issued for playback, the DAC enable, the clock trim
// direction, the receive slot and the fill level.
// An accepted item is held in an input register and moves into the result
// register when the result side is not stalled. One item is accepted per
// cycle while the result side does not stall; the ring state update and
// the two registered read ports of the slot memory settle this rate.
// The memory reads the slots at the next read pointer and the one after it
// every cycle, so an issue never waits on a memory access.
// When the receiver stalls, the result is held; the input register still
// takes one more item, and further items are stalled.
// Reset clears the pointers, fill level, playback flags, clock trim and the
// start threshold (back to 8); slot lengths are undefined until written.
// Writes on the configuration port set the start threshold at once.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_jitter_buffer_ring_top #(
  parameter int SLOT_COUNT      = 32,
  parameter int MAX_FRAME_BYTES = 1023,
  localparam int SLOT_W = $clog2(SLOT_COUNT),
  localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ajb_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [ajb_pkg::STATUS_W-1:0] in_rx_status,
  input  wire logic [LEN_W-1:0]         in_frame_length,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_play_valid,
  output logic [SLOT_W-1:0]             out_play_slot,
  output logic [LEN_W-1:0]              out_play_length,
  output logic                          out_dac_enabled,
  output logic signed [ajb_pkg::TRIM_W-1:0] out_clock_trim,
  output logic                          out_trim_changed,
  output logic [SLOT_W-1:0]             out_receive_slot,
  output logic [SLOT_W-1:0]             out_fill_level,
  input  wire logic                     cfg_we,
  input  wire logic [ajb_pkg::THR_W-1:0] cfg_wdata
);

  localparam int FW = $clog2(SLOT_COUNT + 1);
  localparam int CW = (FW > ajb_pkg::THR_W) ? FW : ajb_pkg::THR_W;
  localparam int JW = CW + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [FW-1:0]     DROP_FILL = FW'(SLOT_COUNT - 1);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_FRAME_BYTES);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + SLOT_W'(1);
  endfunction

  // Input register.
  logic                        iv_r;
  ajb_pkg::kind_t              kind_r;
  ajb_pkg::status_t            status_r;
  logic [LEN_W-1:0]            len_r;

  // Ring state.
  logic [SLOT_W-1:0]           wp_r, wp_nxt;
  logic [SLOT_W-1:0]           rp_r, rp_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic                        playing_r, playing_nxt;
  logic                        busy_r, busy_nxt;
  logic signed [JW-1:0]        jit_r, jit_nxt;
  ajb_pkg::trim_t              trim_r, trim_nxt;
  ajb_pkg::thr_t               thr_r;

  // Result register.
  logic                        ov_r;

  logic                        advance;
  logic                        in_accept;
  logic                        wen;
  logic [LEN_W-1:0]            wdata;
  logic [LEN_W-1:0]            len_sat;
  logic [LEN_W-1:0]            rd0, rd1;
  logic [SLOT_W-1:0]           ra0, ra1;
  logic                        pv;
  logic [SLOT_W-1:0]           ps;
  logic [LEN_W-1:0]            pl;
  logic                        changed;
  logic                        drop;
  logic [SLOT_W-1:0]           rp_a;
  logic [FW-1:0]               fill_b;
  logic signed [JW-1:0]        cur;

  assign advance   = iv_r && (!ov_r || !out_stall);
  assign in_stall  = iv_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign len_sat   = (len_r > MAX_LEN) ? MAX_LEN : len_r;

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    playing_nxt = playing_r;
    busy_nxt    = busy_r;
    wen         = 1'b0;
    wdata       = len_sat;
    pv          = 1'b0;
    ps          = '0;
    pl          = '0;
    drop        = fill_r >= DROP_FILL;
    rp_a        = drop ? next_slot(rp_r) : rp_r;
    fill_b      = fill_r - FW'(drop) + FW'(1);
    case (kind_r)
      ajb_pkg::KIND_FRAME: begin
        case (status_r)
          ajb_pkg::RX_OK: begin
            wen      = 1'b1;
            wp_nxt   = next_slot(wp_r);
            rp_nxt   = rp_a;
            fill_nxt = fill_b;
            if (CW'(fill_b) >= CW'(thr_r)) begin
              playing_nxt = 1'b1;
              if (!busy_r) begin
                pv       = 1'b1;
                ps       = rp_a;
                pl       = (rp_a == wp_r) ? len_sat : (drop ? rd1 : rd0);
                rp_nxt   = next_slot(rp_a);
                fill_nxt = fill_b - FW'(1);
                busy_nxt = 1'b1;
              end
            end
          end
          ajb_pkg::RX_ABORTED: begin
            wen   = 1'b1;
            wdata = '0;
          end
          default: begin
          end
        endcase
      end
      ajb_pkg::KIND_DONE: begin
        if (busy_r) begin
          if (fill_r != '0) begin
            pv       = 1'b1;
            ps       = rp_r;
            pl       = rd0;
            rp_nxt   = next_slot(rp_r);
            fill_nxt = fill_r - FW'(1);
          end else begin
            playing_nxt = 1'b0;
            busy_nxt    = 1'b0;
          end
        end
      end
      ajb_pkg::KIND_RESTART: begin
        wp_nxt   = '0;
        rp_nxt   = '0;
        fill_nxt = '0;
        busy_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    cur      = $signed({1'b0, CW'(fill_nxt)}) - $signed({1'b0, CW'(thr_r)});
    jit_nxt  = jit_r;
    trim_nxt = trim_r;
    changed  = 1'b0;
    if (cur != jit_r) begin
      jit_nxt = cur;
      if (!cur[JW-1] && (cur != '0) && (trim_r != ajb_pkg::TRIM_FASTER)) begin
        trim_nxt = ajb_pkg::TRIM_FASTER;
        changed  = 1'b1;
      end
      if (cur[JW-1] && (trim_r != ajb_pkg::TRIM_SLOWER)) begin
        trim_nxt = ajb_pkg::TRIM_SLOWER;
        changed  = 1'b1;
      end
    end
  end

  // The memory reads the slots that the next item may issue.
  assign ra0 = rst_n ? (advance ? rp_nxt : rp_r) : '0;
  assign ra1 = next_slot(ra0);

  ajb_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (LEN_W)
  ) u_slot_ram (
    .clk    (clk),
    .we     (advance && wen),
    .waddr  (wp_r),
    .wdata  (wdata),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r      <= 1'b0;
      ov_r      <= 1'b0;
      wp_r      <= '0;
      rp_r      <= '0;
      fill_r    <= '0;
      playing_r <= 1'b0;
      busy_r    <= 1'b0;
      jit_r     <= '0;
      trim_r    <= ajb_pkg::TRIM_NONE;
      thr_r     <= ajb_pkg::THR_RESET;
    end else begin
      if (in_accept) begin
        iv_r <= 1'b1;
      end else if (advance) begin
        iv_r <= 1'b0;
      end
      if (advance) begin
        ov_r      <= 1'b1;
        wp_r      <= wp_nxt;
        rp_r      <= rp_nxt;
        fill_r    <= fill_nxt;
        playing_r <= playing_nxt;
        busy_r    <= busy_nxt;
        jit_r     <= jit_nxt;
        trim_r    <= trim_nxt;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r   <= in_kind;
      status_r <= in_rx_status;
      len_r    <= in_frame_length;
    end
    if (advance) begin
      out_play_valid   <= pv;
      out_play_slot    <= ps;
      out_play_length  <= pl;
      out_dac_enabled  <= playing_nxt;
      out_clock_trim   <= trim_nxt;
      out_trim_changed <= changed;
      out_receive_slot <= wp_nxt;
      out_fill_level   <= SLOT_W'(fill_nxt);
    end
  end

  assign out_valid = ov_r;

endmodule

`default_nettype wire

[rtl/ajb_slot_ram.sv]
// ----------------------------------------------------------------------------
// Jitter buffer slot memory
// Slot length store with one write port and two registered read ports.
// A write to an address being read at the same edge is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_slot_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 10,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr0,
  input  wire logic [AW-1:0]    raddr1,
  output logic      [WIDTH-1:0] rdata0,
  output logic      [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr0)) begin
      rdata0 <= wdata;
    end else begin
      rdata0 <= mem[raddr0];
    end
    if (we && (waddr == raddr1)) begin
      rdata1 <= wdata;
    end else begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

[rtl/ajb_checker.sv]
// ----------------------------------------------------------------------------
// Audio jitter buffer checker
// Port level checks on the result channel of the jitter buffer, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_checker #(
  parameter int SLOT_W = 5,
  parameter int LEN_W  = 10
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_play_valid,
  input wire logic [SLOT_W-1:0]             out_play_slot,
  input wire logic [LEN_W-1:0]              out_play_length,
  input wire logic                          out_dac_enabled,
  input wire logic signed [ajb_pkg::TRIM_W-1:0] out_clock_trim,
  input wire logic                          out_trim_changed,
  input wire logic [SLOT_W-1:0]             out_fill_level
);

  a_issue_needs_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_play_valid) |-> out_dac_enabled)
    else $error("Slot issued while playback is disabled.");

  a_idle_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_play_valid) |-> ((out_play_slot == '0) && (out_play_length == '0)))
    else $error("Slot fields not zero on an item without an issue.");

  a_trim_change_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trim_changed) |-> (out_clock_trim != ajb_pkg::TRIM_NONE))
    else $error("Clock trim reported changed to no direction.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_fill_level)
      && $stable(out_play_valid) && $stable(out_clock_trim)))
    else $error("Stalled result item changed.");

endmodule

bind audio_jitter_buffer_ring_top ajb_checker #(
  .SLOT_W (SLOT_W),
  .LEN_W  (LEN_W)
) u_ajb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_play_valid   (out_play_valid),
  .out_play_slot    (out_play_slot),
  .out_play_length  (out_play_length),
  .out_dac_enabled  (out_dac_enabled),
  .out_clock_trim   (out_clock_trim),
  .out_trim_changed (out_trim_changed),
  .out_fill_level   (out_fill_level)
);

`default_nettype wire

[verif/ajb_ring_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jitter buffer ring scoreboard
// Tracks the ring pointers, fill level, playback flags and clock trim for every
// accepted event, and compares each status report from the block with the
// oldest one predicted.
// ----------------------------------------------------------------------------
package ajb_ring_scoreboard_pkg;

  localparam int RING_SLOTS = 32;
  localparam int LENGTH_W   = 10;
  localparam int SLOT_IDX_W = 5;

  localparam ajb_pkg::kind_t   KIND_UNUSED = 2'd3;
  localparam ajb_pkg::status_t RX_DISCARD  = 2'd2;
  localparam ajb_pkg::status_t RX_OTHER    = 2'd3;

  typedef struct {
    logic                  play_valid;
    logic [SLOT_IDX_W-1:0] play_slot;
    logic [LENGTH_W-1:0]   play_length;
    logic                  dac_enabled;
    ajb_pkg::trim_t        clock_trim;
    logic                  trim_changed;
    logic [SLOT_IDX_W-1:0] receive_slot;
    logic [SLOT_IDX_W-1:0] fill_level;
  } ring_report_t;

  class ring_scoreboard;
    ring_report_t          due_reports[$];
    logic [LENGTH_W-1:0]   slot_len[RING_SLOTS];
    logic [SLOT_IDX_W-1:0] wr_ptr = '0;
    logic [SLOT_IDX_W-1:0] rd_ptr = '0;
    int                    fill = 0;
    bit                    playing = 1'b0;
    bit                    dac_busy = 1'b0;
    int                    last_jitter = 0;
    ajb_pkg::trim_t        trim_dir = ajb_pkg::TRIM_NONE;
    int                    threshold = int'(ajb_pkg::THR_RESET);
    int                    failures = 0;

    function void issue_slot(inout ring_report_t rep);
      rep.play_valid  = 1'b1;
      rep.play_slot   = rd_ptr;
      rep.play_length = slot_len[rd_ptr];
      rd_ptr          = rd_ptr + 1'b1;
      if (fill > 0) fill--;
      dac_busy = 1'b1;
    endfunction

    function void advance_ring(ajb_pkg::kind_t kind, ajb_pkg::status_t status,
                               logic [LENGTH_W-1:0] len);
      ring_report_t rep;
      int           jitter;
      rep = '{default: '0};
      case (kind)
        ajb_pkg::KIND_FRAME: begin
          if (status == ajb_pkg::RX_OK) begin
            if (fill >= RING_SLOTS - 1) begin
              rd_ptr = rd_ptr + 1'b1;
              fill--;
            end
            slot_len[wr_ptr] = len;
            wr_ptr = wr_ptr + 1'b1;
            fill++;
            if (fill >= threshold) begin
              playing = 1'b1;
              if (!dac_busy) issue_slot(rep);
            end
          end else if (status == ajb_pkg::RX_ABORTED) begin
            slot_len[wr_ptr] = '0;
          end
        end
        ajb_pkg::KIND_DONE: begin
          if (dac_busy) begin
            if (fill > 0) begin
              issue_slot(rep);
            end else begin
              playing  = 1'b0;
              dac_busy = 1'b0;
            end
          end
        end
        ajb_pkg::KIND_RESTART: begin
          wr_ptr   = '0;
          rd_ptr   = '0;
          fill     = 0;
          dac_busy = 1'b0;
        end
        default: ;
      endcase
      jitter = fill - threshold;
      if (jitter != last_jitter) begin
        last_jitter = jitter;
        if (jitter > 0 && trim_dir != ajb_pkg::TRIM_FASTER) begin
          trim_dir = ajb_pkg::TRIM_FASTER;
          rep.trim_changed = 1'b1;
        end
        if (jitter < 0 && trim_dir != ajb_pkg::TRIM_SLOWER) begin
          trim_dir = ajb_pkg::TRIM_SLOWER;
          rep.trim_changed = 1'b1;
        end
      end
      rep.dac_enabled  = playing;
      rep.clock_trim   = trim_dir;
      rep.receive_slot = wr_ptr;
      rep.fill_level   = fill[SLOT_IDX_W-1:0];
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        failures++;
      end
    endfunction

    function void check_report(ring_report_t seen);
      ring_report_t want;
      if (due_reports.size() == 0) begin
        $error("report arrived with no item outstanding");
        failures++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("play_valid", want.play_valid, seen.play_valid);
      compare_field("play_slot", want.play_slot, seen.play_slot);
      compare_field("play_length", want.play_length, seen.play_length);
      compare_field("dac_enabled", want.dac_enabled, seen.dac_enabled);
      compare_field("clock_trim", want.clock_trim, seen.clock_trim);
      compare_field("trim_changed", want.trim_changed, seen.trim_changed);
      compare_field("receive_slot", want.receive_slot, seen.receive_slot);
      compare_field("fill_level", want.fill_level, seen.fill_level);
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction

    function void check_drained();
      if (due_reports.size() != 0) begin
        $error("%0d reports never arrived", due_reports.size());
        failures++;
      end
    endfunction
  endclass

endpackage

[verif/audio_jitter_buffer_ring_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio jitter buffer ring testbench
// Drives frame, playback-done and restart events through the ring under
// random idling on both sides before phase 8, changes the start threshold
// between phases and checks every status report against the scoreboard's
// prediction.
module audio_jitter_buffer_ring_top_tb;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 80;
  localparam int LEN_W           = ajb_ring_scoreboard_pkg::LENGTH_W;
  localparam int IDX_W           = ajb_ring_scoreboard_pkg::SLOT_IDX_W;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  ajb_pkg::kind_t        in_kind = ajb_pkg::KIND_FRAME;
  ajb_pkg::status_t      in_rx_status = ajb_pkg::RX_OK;
  logic [LEN_W-1:0]      in_frame_length = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  ajb_pkg::thr_t         cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_play_valid;
  logic [IDX_W-1:0]      out_play_slot;
  logic [LEN_W-1:0]      out_play_length;
  logic                  out_dac_enabled;
  ajb_pkg::trim_t        out_clock_trim;
  logic                  out_trim_changed;
  logic [IDX_W-1:0]      out_receive_slot;
  logic [IDX_W-1:0]      out_fill_level;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int frame_pct = 70;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  ajb_ring_scoreboard_pkg::ring_scoreboard sb;

  audio_jitter_buffer_ring_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_status     (in_rx_status),
    .in_frame_length  (in_frame_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_play_valid   (out_play_valid),
    .out_play_slot    (out_play_slot),
    .out_play_length  (out_play_length),
    .out_dac_enabled  (out_dac_enabled),
    .out_clock_trim   (out_clock_trim),
    .out_trim_changed (out_trim_changed),
    .out_receive_slot (out_receive_slot),
    .out_fill_level   (out_fill_level),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_asks != hold_seen) || (hold_left > 1) ||
                 ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    ajb_ring_scoreboard_pkg::ring_report_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.play_valid   = out_play_valid;
      seen.play_slot    = out_play_slot;
      seen.play_length  = out_play_length;
      seen.dac_enabled  = out_dac_enabled;
      seen.clock_trim   = out_clock_trim;
      seen.trim_changed = out_trim_changed;
      seen.receive_slot = out_receive_slot;
      seen.fill_level   = out_fill_level;
      sb.check_report(seen);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_event(input ajb_pkg::kind_t kind, input ajb_pkg::status_t status,
                            input logic [LEN_W-1:0] len);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_rx_status    <= status;
    in_frame_length <= len;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.advance_ring(kind, status, len);
  endtask

  task automatic send_random_event();
    int                 pick;
    ajb_pkg::kind_t     kind;
    ajb_pkg::status_t   status;
    logic [LEN_W-1:0]   len;
    pick = $urandom_range(99);
    if (pick < frame_pct) kind = ajb_pkg::KIND_FRAME;
    else if (pick < frame_pct + 2) kind = ajb_pkg::KIND_RESTART;
    else if (pick < frame_pct + 3) kind = ajb_ring_scoreboard_pkg::KIND_UNUSED;
    else kind = ajb_pkg::KIND_DONE;
    pick = $urandom_range(99);
    if (pick < 85) status = ajb_pkg::RX_OK;
    else if (pick < 91) status = ajb_pkg::RX_ABORTED;
    else if (pick < 96) status = ajb_ring_scoreboard_pkg::RX_DISCARD;
    else status = ajb_ring_scoreboard_pkg::RX_OTHER;
    pick = $urandom_range(9);
    if (pick == 0) len = '0;
    else if (pick == 1) len = '1;
    else len = LEN_W'($urandom);
    send_event(kind, status, len);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input ajb_pkg::thr_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.threshold  = int'(value);
  endtask

  initial begin
    ajb_pkg::thr_t phase_threshold[PHASES];
    int            phase_frame_pct[PHASES];
    phase_threshold = '{5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd31,
                        5'd3, 5'd24, 5'd0, 5'd5, 5'd31, 5'd12};
    phase_frame_pct = '{70, 92, 60, 80, 50, 95, 65, 85, 75, 55, 90, 70};
    sb = new;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct    = 37;
    receiver_idle_pct <= 61;

    send_event(ajb_pkg::KIND_DONE, ajb_pkg::RX_OK, 10'd0);
    send_event(ajb_ring_scoreboard_pkg::KIND_UNUSED,
               ajb_ring_scoreboard_pkg::RX_OTHER, 10'h3FF);
    send_event(ajb_ring_scoreboard_pkg::KIND_UNUSED, ajb_pkg::RX_OK, 10'd0);
    send_event(ajb_pkg::KIND_FRAME, ajb_ring_scoreboard_pkg::RX_DISCARD, 10'h3FF);
    send_event(ajb_pkg::KIND_FRAME, ajb_ring_scoreboard_pkg::RX_OTHER, 10'h155);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_ABORTED, 10'h3FF);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_ABORTED, 10'd0);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'd0);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'h3FF);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'h2AA);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'h155);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'd1);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'd512);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'd7);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'h3FE);
    send_event(ajb_pkg::KIND_DONE, ajb_pkg::RX_OK, 10'd0);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_ABORTED, 10'd99);
    send_event(ajb_pkg::KIND_RESTART, ajb_ring_scoreboard_pkg::RX_OTHER, 10'h3FF);
    send_event(ajb_pkg::KIND_DONE, ajb_pkg::RX_OK, 10'd0);
    send_event(ajb_pkg::KIND_FRAME, ajb_pkg::RX_OK, 10'd100);
    send_event(ajb_pkg::KIND_DONE, ajb_ring_scoreboard_pkg::RX_DISCARD, 10'h200);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) begin
        sender_idle_pct    = 61;
        receiver_idle_pct <= 37;
      end else if (ph == 8) begin
        sender_idle_pct    = 0;
        receiver_idle_pct <= 0;
      end
      pause_until_drained();
      write_threshold(phase_threshold[ph]);
      frame_pct = phase_frame_pct[ph];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ((ph == 1 || ph == 9) && i == 40) hold_asks <= hold_asks + 1;
        send_random_event();
      end
    end

    pause_until_drained();
    repeat (20) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
